[rtl/core/assert_macros.svh]
// Assertion macros shared by the MD5 stream hasher RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/md5_pkg.sv]
// Types, constants and round tables for the MD5 stream hasher.
// No dependencies; used by the channel interfaces, md5_round and the top level.
package md5_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } md5_state_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } abcd_type;

   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   localparam int BUF_WORDS = 16;

   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [1:0] LAST_IDX = 2'd3;
   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam abcd_type CHAIN_INIT = '{
      a: 32'h67452301,
      b: 32'hefcdab89,
      c: 32'h98badcfe,
      d: 32'h10325476
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // rotate amount per quarter, indexed by round bits [5:4] then [1:0]
   localparam logic [4:0] SHIFT_TAB [4][4] = '{
      '{5'd7, 5'd12, 5'd17, 5'd22},
      '{5'd5, 5'd9,  5'd14, 5'd20},
      '{5'd4, 5'd11, 5'd16, 5'd23},
      '{5'd6, 5'd10, 5'd15, 5'd21}
   };

   // message word used by a round
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [7:0] r8;
      logic [7:0] k8;
      r8 = {2'b00, rnd};
      unique case (rnd[5:4])
         2'd0: k8 = r8;
         2'd1: k8 = r8 * 8'd5 + 8'd1;
         2'd2: k8 = r8 * 8'd3 + 8'd5;
         2'd3: k8 = r8 * 8'd7;
      endcase
      return k8[3:0];
   endfunction

endpackage

[rtl/core/md5_chan_if.sv]
// Valid/ready channel interfaces for the MD5 stream hasher.
// Depends on md5_pkg.
interface md5_req_if;
   import md5_pkg::*;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface md5_rsp_if;
   import md5_pkg::*;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;
   logic [63:0] message_bytes;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, output message_bytes, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, input message_bytes, output ready);
endinterface

[rtl/core/md5_round.sv]
// One MD5 round: boolean function, four-way add, rotate, and word shuffle.
// Depends on md5_pkg for the round tables and the working-word struct.
module md5_round (
   input  logic [5:0]         rnd,
   input  md5_pkg::abcd_type  work,
   input  logic [31:0]        msg_word,
   output md5_pkg::abcd_type  work_next
);
   import md5_pkg::*;

   logic [31:0] f_val;
   logic [31:0] sum;
   logic [63:0] rot_wide;
   logic [4:0]  shift;

   always_comb begin
      unique case (rnd[5:4])
         2'd0: f_val = (work.b & work.c) | (~work.b & work.d);
         2'd1: f_val = (work.d & work.b) | (~work.d & work.c);
         2'd2: f_val = work.b ^ work.c ^ work.d;
         2'd3: f_val = work.c ^ (work.b | ~work.d);
      endcase
   end

   assign shift    = SHIFT_TAB[rnd[5:4]][rnd[1:0]];
   assign sum      = work.a + f_val + ROUND_CONST[rnd] + msg_word;
   // left rotate: upper half of the doubled word shifted left
   assign rot_wide = {sum, sum} << shift;

   assign work_next.a = work.d;
   assign work_next.b = work.b + rot_wide[63:32];
   assign work_next.c = work.b;
   assign work_next.d = work.c;

endmodule

[rtl/core/md5_stream_hasher.sv]
// MD5 stream hasher: append byte and finish transactions in, four digest words out.
// Append: byte stored in the block buffer; a block-filling byte starts compression.
// Finish: pad and compress, plus a length-only block when fill >= 56, then four
// result transactions. One item at a time; the single-port round loop sets it.
// Reset is synchronous, active high: chaining words to the IV, counts cleared;
// the block buffer memory is not cleared.
`include "assert_macros.svh"

module md5_stream_hasher (
   input logic     clock,
   input logic     reset,
   md5_req_if.sink   req_ch,
   md5_rsp_if.source rsp_ch
);
   import md5_pkg::*;

   md5_state_type state_ff, state_in;

   logic [5:0]  fill_ff, fill_in;
   logic [63:0] count_ff, count_in;
   abcd_type    chain_ff, chain_in;
   abcd_type    work_ff, work_in;
   abcd_type    round_out;
   logic [5:0]  rnd_ff, rnd_in;
   logic [5:0]  pad_pos_ff, pad_pos_in;
   logic        fin_ff, fin_in;
   logic        pad2_ff, pad2_in;
   logic        len_here_ff, len_here_in;
   logic        mark_ff, mark_in;
   logic [1:0]  idx_ff, idx_in;

   logic [3:0][7:0] buf_mem [BUF_WORDS];
   logic [31:0] rd_data_ff;
   logic [3:0]  rd_addr;
   logic        wr_en;
   logic [5:0]  wr_pos;
   logic [7:0]  wr_byte;
   logic [63:0] bit_len;
   logic        req_acc;
   logic        rsp_acc;

   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_acc = rsp_ch.valid && rsp_ch.ready;
   assign bit_len = {count_ff[60:0], 3'b000};

   md5_round u_round (
      .rnd       (rnd_ff),
      .work      (work_ff),
      .msg_word  (rd_data_ff),
      .work_next (round_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.req_type == REQ_FINISH) begin
                  state_in = ST_PAD;
               end else if (fill_ff == LAST_POS) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_PAD: begin
            if (pad_pos_ff == LAST_POS) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == LAST_POS) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (pad2_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_acc && idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and memory port controls
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      rsp_ch.valid = (state_ff == ST_EMIT);
      wr_en        = (req_acc && req_ch.req_type == REQ_APPEND) || (state_ff == ST_PAD);
      if (state_ff == ST_PAD) begin
         wr_pos = pad_pos_ff;
         if (mark_ff) begin
            wr_byte = PAD_MARK;
         end else if (len_here_ff && pad_pos_ff >= LEN_POS) begin
            wr_byte = bit_len[{pad_pos_ff[2:0], 3'b000} +: 8];
         end else begin
            wr_byte = 8'h00;
         end
      end else begin
         wr_pos  = fill_ff;
         wr_byte = req_ch.data_byte;
      end
      // prefetch the word for the next round
      if (state_ff == ST_LOAD) begin
         rd_addr = msg_index(6'd0);
      end else begin
         rd_addr = msg_index(rnd_ff + 6'd1);
      end
   end

   always_comb begin
      rsp_ch.word_index    = idx_ff;
      rsp_ch.last_word     = (idx_ff == LAST_IDX);
      rsp_ch.message_bytes = count_ff;
      unique case (idx_ff)
         2'd0: rsp_ch.digest_word = chain_ff.a;
         2'd1: rsp_ch.digest_word = chain_ff.b;
         2'd2: rsp_ch.digest_word = chain_ff.c;
         2'd3: rsp_ch.digest_word = chain_ff.d;
      endcase
   end

   // datapath next values
   always_comb begin
      fill_in     = fill_ff;
      count_in    = count_ff;
      chain_in    = chain_ff;
      work_in     = work_ff;
      rnd_in      = rnd_ff;
      pad_pos_in  = pad_pos_ff;
      fin_in      = fin_ff;
      pad2_in     = pad2_ff;
      len_here_in = len_here_ff;
      mark_in     = mark_ff;
      idx_in      = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.req_type == REQ_APPEND) begin
                  fill_in  = fill_ff + 6'd1;
                  count_in = count_ff + 64'd1;
               end else begin
                  fin_in      = 1'b1;
                  pad_pos_in  = fill_ff;
                  mark_in     = 1'b1;
                  pad2_in     = (fill_ff >= LEN_POS);
                  len_here_in = (fill_ff < LEN_POS);
               end
            end
         end
         ST_PAD: begin
            mark_in    = 1'b0;
            pad_pos_in = pad_pos_ff + 6'd1;
         end
         ST_LOAD: begin
            work_in = chain_ff;
            rnd_in  = 6'd0;
         end
         ST_ROUND: begin
            work_in = round_out;
            rnd_in  = rnd_ff + 6'd1;
         end
         ST_FOLD: begin
            chain_in.a = chain_ff.a + work_ff.a;
            chain_in.b = chain_ff.b + work_ff.b;
            chain_in.c = chain_ff.c + work_ff.c;
            chain_in.d = chain_ff.d + work_ff.d;
            // length-only block still to go
            if (fin_ff && pad2_ff) begin
               pad2_in     = 1'b0;
               pad_pos_in  = 6'd0;
               len_here_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == LAST_IDX) begin
                  chain_in = CHAIN_INIT;
                  fill_in  = 6'd0;
                  count_in = 64'd0;
                  fin_in   = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= 6'd0;
         count_ff    <= 64'd0;
         chain_ff    <= CHAIN_INIT;
         rnd_ff      <= 6'd0;
         pad_pos_ff  <= 6'd0;
         fin_ff      <= 1'b0;
         pad2_ff     <= 1'b0;
         len_here_ff <= 1'b0;
         mark_ff     <= 1'b0;
         idx_ff      <= 2'd0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         chain_ff    <= chain_in;
         rnd_ff      <= rnd_in;
         pad_pos_ff  <= pad_pos_in;
         fin_ff      <= fin_in;
         pad2_ff     <= pad2_in;
         len_here_ff <= len_here_in;
         mark_ff     <= mark_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   // block buffer: byte-lane writes, registered word reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[wr_pos[5:2]][wr_pos[1:0]] <= wr_byte;
      end
      rd_data_ff <= buf_mem[rd_addr];
   end

   `ASSERT_HOLDS(a_no_write_in_compress, clock, reset, !(wr_en && (state_ff == ST_LOAD || state_ff == ST_ROUND)), "buffer written during compression")
   `ASSERT_HOLDS(a_fill_tracks_count, clock, reset, fill_ff == count_ff[5:0], "fill count out of step with byte count")
   `ASSERT_HOLDS(a_emit_final_block, clock, reset, (state_ff != ST_EMIT) || (fin_ff && !pad2_ff), "digest out before final block")
   `ASSERT_NEXT(a_restart_after_digest, clock, reset, rsp_acc && rsp_ch.last_word, count_ff == 64'd0 && chain_ff == CHAIN_INIT && state_ff == ST_IDLE, "no restart after digest")

endmodule
